// ===== sv/assert_macros.svh =====
// assertion macros used by the top-level rtl file
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define ASSERT_CLK(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error(msg);

// condition must never be seen at a clock edge outside reset
`define ASSERT_NEVER(lbl, clk, rst, cond, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error(msg);

`endif

// ===== sv/sslt_pkg.sv =====
// types, constants and helpers of the shadow slot lease table
// no dependencies
`default_nettype none

package sslt_pkg;

   localparam int SLOTS       = 16;
   localparam int OWNER_BITS  = 16;
   localparam int SLOT_BITS   = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int LEVEL_W     = 7;
   localparam int ID_W        = 16;
   localparam int HELD_W      = 4;
   localparam int OP_W        = 2;
   localparam int KIND_W      = 3;
   localparam int MAX_RESULTS = 16;
   localparam int CNT_BITS    = $clog2(MAX_RESULTS + 1);
   localparam int CFG_ADDR_W  = 2;
   localparam int CFG_DATA_W  = 7;
   localparam int QM_W        = 2;

   localparam logic [OP_W-1:0] OP_REQUEST = 2'd0;
   localparam logic [OP_W-1:0] OP_TICK    = 2'd1;
   localparam logic [OP_W-1:0] OP_RETURN  = 2'd2;

   localparam logic [KIND_W-1:0] EV_GRANTED  = 3'd0;
   localparam logic [KIND_W-1:0] EV_TOUCHED  = 3'd1;
   localparam logic [KIND_W-1:0] EV_REFUSED  = 3'd2;
   localparam logic [KIND_W-1:0] EV_ACTIVE   = 3'd3;
   localparam logic [KIND_W-1:0] EV_RELEASED = 3'd4;
   localparam logic [KIND_W-1:0] EV_RETURNED = 3'd5;

   localparam logic [CFG_ADDR_W-1:0] CFG_QUALITY    = 2'd0;
   localparam logic [CFG_ADDR_W-1:0] CFG_FADE_STEP  = 2'd1;
   localparam logic [CFG_ADDR_W-1:0] CFG_FULL_LEVEL = 2'd2;

   localparam logic [QM_W-1:0] QM_NONE   = 2'd0;
   localparam logic [QM_W-1:0] QM_PLAYER = 2'd1;
   localparam logic [QM_W-1:0] QM_ALL    = 2'd2;

   localparam logic [QM_W-1:0]    QUALITY_RESET = QM_ALL;
   localparam logic [LEVEL_W-1:0] STEP_RESET    = 7'd3;
   localparam logic [LEVEL_W-1:0] FULL_RESET    = 7'd100;

   localparam logic [2:0] CMD_NONE      = 3'd0;
   localparam logic [2:0] CMD_REFUSE    = 3'd1;
   localparam logic [2:0] CMD_TOUCH     = 3'd2;
   localparam logic [2:0] CMD_RETURN    = 3'd3;
   localparam logic [2:0] CMD_GRANT0    = 3'd4;
   localparam logic [2:0] CMD_GRANT_IDX = 3'd5;
   localparam logic [2:0] CMD_TICK_SLOT = 3'd6;

   typedef logic [SLOT_BITS-1:0]  slot_idx_type;
   typedef logic [OWNER_BITS-1:0] owner_type;
   typedef logic [LEVEL_W-1:0]    level_type;

   typedef struct packed {
      logic [OP_W-1:0]   operation;
      logic [ID_W-1:0]   owner_id;
      logic              has_shadow;
      logic [HELD_W-1:0] held_slot;
      logic              is_pedestrian;
      logic              is_player_one;
      logic              has_driver;
      logic              player_fast;
   } req_beat_type;

   typedef struct packed {
      logic [KIND_W-1:0] event_kind;
      logic [HELD_W-1:0] slot;
      logic [ID_W-1:0]   slot_owner;
      level_type         level;
      logic              last;
   } rsp_beat_type;

   typedef struct packed {
      logic       latch;
      logic       rd;
      logic       sel_held;
      logic       idx_tick;
      logic       idx_scan;
      logic       idx_inc;
      logic       idx_dec;
      logic [2:0] op;
      logic       clear_keep;
   } cmd_type;

   typedef struct packed {
      logic [OP_W-1:0] operation;
      logic            allowed;
      logic            has_shadow;
      logic            held_ok;
      logic            has_driver;
      logic            player_fast;
      logic            idx_used;
      logic            idx_is_one;
      logic            idx_last;
      logic            out_free;
      logic            rep_ok;
   } sts_type;

   function automatic slot_idx_type held_to_idx(input logic [HELD_W-1:0] h);
      logic [31:0] w;
      w = {{(32-HELD_W){1'b0}}, h};
      return w[SLOT_BITS-1:0];
   endfunction

   function automatic logic [HELD_W-1:0] idx_to_slot(input slot_idx_type i);
      logic [31:0] w;
      w = 32'(i);
      return w[HELD_W-1:0];
   endfunction

   function automatic owner_type id_to_owner(input logic [ID_W-1:0] id);
      logic [63:0] w;
      w = {{(64-ID_W){1'b0}}, id};
      return w[OWNER_BITS-1:0];
   endfunction

   function automatic logic [ID_W-1:0] owner_to_id(input owner_type o);
      logic [63:0] w;
      w = 64'(o);
      return w[ID_W-1:0];
   endfunction

endpackage

`default_nettype wire

// ===== sv/sslt_ifs.sv =====
// channel interfaces of the shadow slot lease table: request, result, csr write
// depends on sslt_pkg
`default_nettype none

interface sslt_req_if;
   logic                  valid;
   logic                  ready;
   sslt_pkg::req_beat_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

interface sslt_rsp_if;
   logic                  valid;
   logic                  ready;
   sslt_pkg::rsp_beat_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

interface sslt_csr_if;
   logic                                valid;
   logic                                ready;
   logic [sslt_pkg::CFG_ADDR_W-1:0]     addr;
   logic [sslt_pkg::CFG_DATA_W-1:0]     wdata;
   modport source (output valid, output addr, output wdata, input ready);
   modport sink (input valid, input addr, input wdata, output ready);
endinterface

`default_nettype wire

// ===== sv/sslt_ram.sv =====
// generic single write port ram with registered read
// no dependencies
`default_nettype none

module sslt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                                       clock,
   input  wire logic                                       we,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  wire logic [WIDTH-1:0]                           wdata,
   input  wire logic                                       re,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic      [WIDTH-1:0]                           rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

// ===== sv/sslt_ctrl.sv =====
// sequencer of the lease table: decodes each item and steps the datapath
// depends on sslt_pkg
`default_nettype none

module sslt_ctrl (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire sslt_pkg::sts_type sts,
   output sslt_pkg::cmd_type      cmd
);
   import sslt_pkg::*;

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_DECODE = 3'd1;
   localparam logic [2:0] S_TOUCH  = 3'd2;
   localparam logic [2:0] S_RET    = 3'd3;
   localparam logic [2:0] S_SCAN   = 3'd4;
   localparam logic [2:0] S_TRD    = 3'd5;
   localparam logic [2:0] S_TEX    = 3'd6;

   logic [2:0] state_ff;
   logic [2:0] state_in;

   always_comb begin
      state_in  = state_ff;
      req_ready = 1'b0;
      cmd       = '0;
      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.latch = 1'b1;
               state_in  = S_DECODE;
            end
         end
         S_DECODE: begin
            unique case (sts.operation)
               OP_REQUEST: begin
                  if (!sts.allowed || (sts.has_shadow && !sts.held_ok) ||
                      (!sts.has_shadow && sts.has_driver && sts.player_fast)) begin
                     if (sts.out_free) begin
                        cmd.op   = CMD_REFUSE;
                        state_in = S_IDLE;
                     end
                  end else if (sts.has_shadow) begin
                     cmd.rd       = 1'b1;
                     cmd.sel_held = 1'b1;
                     state_in     = S_TOUCH;
                  end else if (!sts.has_driver) begin
                     if (sts.out_free) begin
                        cmd.op   = CMD_GRANT0;
                        state_in = S_IDLE;
                     end
                  end else begin
                     cmd.idx_scan = 1'b1;
                     state_in     = S_SCAN;
                  end
               end
               OP_TICK: begin
                  cmd.idx_tick = 1'b1;
                  state_in     = S_TRD;
               end
               OP_RETURN: begin
                  if (sts.held_ok) begin
                     cmd.rd       = 1'b1;
                     cmd.sel_held = 1'b1;
                     state_in     = S_RET;
                  end else if (sts.out_free) begin
                     cmd.op   = CMD_REFUSE;
                     state_in = S_IDLE;
                  end
               end
               default: begin
                  state_in = S_IDLE;
               end
            endcase
         end
         S_TOUCH: begin
            if (sts.out_free) begin
               cmd.op   = CMD_TOUCH;
               state_in = S_IDLE;
            end
         end
         S_RET: begin
            if (sts.out_free) begin
               cmd.op   = CMD_RETURN;
               state_in = S_IDLE;
            end
         end
         S_SCAN: begin
            if (!sts.idx_used) begin
               if (sts.out_free) begin
                  cmd.op   = CMD_GRANT_IDX;
                  state_in = S_IDLE;
               end
            end else if (sts.idx_is_one) begin
               if (sts.out_free) begin
                  cmd.op   = CMD_REFUSE;
                  state_in = S_IDLE;
               end
            end else begin
               cmd.idx_dec = 1'b1;
            end
         end
         S_TRD: begin
            if (sts.idx_used) begin
               cmd.rd   = 1'b1;
               state_in = S_TEX;
            end else if (sts.idx_last) begin
               cmd.clear_keep = 1'b1;
               state_in       = S_IDLE;
            end else begin
               cmd.idx_inc = 1'b1;
            end
         end
         S_TEX: begin
            if (sts.out_free || !sts.rep_ok) begin
               cmd.op = CMD_TICK_SLOT;
               if (sts.idx_last) begin
                  cmd.clear_keep = 1'b1;
                  state_in       = S_IDLE;
               end else begin
                  cmd.idx_inc = 1'b1;
                  state_in    = S_TRD;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

// ===== sv/sslt_dpath.sv =====
// lease table datapath: item latch, csr registers, slot flags, owner/level ram,
// slot index and result counters, fade arithmetic and the result register
// depends on sslt_pkg and sslt_ram
`default_nettype none

module sslt_dpath (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire sslt_pkg::req_beat_type          req_data,
   input  wire sslt_pkg::cmd_type               cmd,
   output sslt_pkg::sts_type                    sts,
   input  wire logic                            csr_valid,
   input  wire logic [sslt_pkg::CFG_ADDR_W-1:0] csr_addr,
   input  wire logic [sslt_pkg::CFG_DATA_W-1:0] csr_wdata,
   output logic                                 rsp_valid,
   output sslt_pkg::rsp_beat_type               rsp_data,
   input  wire logic                            rsp_ready
);
   import sslt_pkg::*;

   localparam int RAM_W = OWNER_BITS + LEVEL_W;

   req_beat_type      item_ff, item_in;
   logic [QM_W-1:0]   quality_ff, quality_in;
   level_type         step_ff, step_in;
   level_type         full_ff, full_in;
   logic [SLOTS-1:0]  used_ff, used_in;
   logic [SLOTS-1:0]  keep_ff, keep_in;
   logic [SLOTS-1:0]  lvv_ff, lvv_in;
   slot_idx_type      idx_ff, idx_in;
   logic [CNT_BITS-1:0] cnt_ff, cnt_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_beat_type      rsp_data_ff, rsp_data_in;

   logic              ram_we;
   slot_idx_type      ram_waddr;
   slot_idx_type      ram_raddr;
   logic [RAM_W-1:0]  ram_wdata;
   logic [RAM_W-1:0]  ram_rdata;
   owner_type         rd_owner;
   level_type         rd_level;
   owner_type         w_owner;
   level_type         w_level;

   slot_idx_type      held_idx;
   slot_idx_type      grant_idx;
   owner_type         held_owner;
   level_type         held_level;
   owner_type         tick_owner;
   level_type         tick_old;
   level_type         tick_new;
   logic [LEVEL_W:0]  up_sum;
   logic [SLOTS-1:0]  upper_mask;
   logic              any_above;
   logic              out_free;
   logic              emit;
   rsp_beat_type      beat;

   assign held_idx  = held_to_idx(item_ff.held_slot);
   assign ram_raddr = cmd.sel_held ? held_idx : idx_ff;
   assign ram_wdata = {w_owner, w_level};
   assign rd_owner  = ram_rdata[RAM_W-1:LEVEL_W];
   assign rd_level  = ram_rdata[LEVEL_W-1:0];

   sslt_ram #(
      .WIDTH(RAM_W),
      .DEPTH(SLOTS)
   ) u_table (
      .clock(clock),
      .we   (ram_we),
      .waddr(ram_waddr),
      .wdata(ram_wdata),
      .re   (cmd.rd),
      .raddr(ram_raddr),
      .rdata(ram_rdata)
   );

   // unwritten entries read as their reset value
   assign held_owner = used_ff[held_idx] ? rd_owner : '0;
   assign held_level = lvv_ff[held_idx] ? rd_level : '0;
   assign tick_owner = used_ff[idx_ff] ? rd_owner : '0;
   assign tick_old   = lvv_ff[idx_ff] ? rd_level : '0;

   assign up_sum = {1'b0, tick_old} + {1'b0, step_ff};

   always_comb begin
      if (keep_ff[idx_ff]) begin
         tick_new = (up_sum > {1'b0, full_ff}) ? full_ff : up_sum[LEVEL_W-1:0];
      end else begin
         tick_new = (tick_old > step_ff) ? (tick_old - step_ff) : '0;
      end
   end

   always_comb begin
      for (int j = 0; j < SLOTS; j++) begin
         upper_mask[j] = (j > int'(idx_ff));
      end
   end

   assign any_above = |(used_ff & upper_mask);
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign grant_idx = (cmd.op == CMD_GRANT0) ? '0 : idx_ff;

   always_comb begin
      sts.operation   = item_ff.operation;
      sts.has_shadow  = item_ff.has_shadow;
      sts.has_driver  = item_ff.has_driver;
      sts.player_fast = item_ff.player_fast;
      sts.held_ok     = 32'(item_ff.held_slot) < 32'(SLOTS);
      sts.idx_used    = used_ff[idx_ff];
      sts.idx_is_one  = idx_ff == SLOT_BITS'(1);
      sts.idx_last    = idx_ff == SLOT_BITS'(SLOTS - 1);
      sts.out_free    = out_free;
      sts.rep_ok      = cnt_ff < CNT_BITS'(MAX_RESULTS);
      case (quality_ff)
         QM_ALL:    sts.allowed = 1'b1;
         QM_PLAYER: sts.allowed = item_ff.is_pedestrian && item_ff.is_player_one;
         default:   sts.allowed = 1'b0;
      endcase
   end

   always_comb begin
      item_in      = item_ff;
      quality_in   = quality_ff;
      step_in      = step_ff;
      full_in      = full_ff;
      used_in      = used_ff;
      keep_in      = keep_ff;
      lvv_in       = lvv_ff;
      idx_in       = idx_ff;
      cnt_in       = cnt_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      ram_we       = 1'b0;
      ram_waddr    = idx_ff;
      w_owner      = '0;
      w_level      = '0;
      emit         = 1'b0;
      beat         = '0;
      beat.last    = 1'b1;

      if (cmd.latch) begin
         item_in = req_data;
      end
      if (cmd.idx_tick) begin
         idx_in = '0;
         cnt_in = '0;
      end
      if (cmd.idx_scan) begin
         idx_in = SLOT_BITS'(SLOTS - 1);
      end
      if (cmd.idx_inc) begin
         idx_in = idx_ff + SLOT_BITS'(1);
      end
      if (cmd.idx_dec) begin
         idx_in = idx_ff - SLOT_BITS'(1);
      end

      case (cmd.op)
         CMD_REFUSE: begin
            emit            = 1'b1;
            beat.event_kind = EV_REFUSED;
         end
         CMD_TOUCH: begin
            keep_in[held_idx] = 1'b1;
            emit              = 1'b1;
            beat.event_kind   = EV_TOUCHED;
            beat.slot         = item_ff.held_slot;
            beat.slot_owner   = owner_to_id(held_owner);
            beat.level        = held_level;
         end
         CMD_RETURN: begin
            used_in[held_idx] = 1'b0;
            lvv_in[held_idx]  = 1'b1;
            ram_we            = 1'b1;
            ram_waddr         = held_idx;
            w_level           = held_level;
            emit              = 1'b1;
            beat.event_kind   = EV_RETURNED;
            beat.slot         = item_ff.held_slot;
            beat.slot_owner   = owner_to_id(held_owner);
            beat.level        = held_level;
         end
         CMD_GRANT0, CMD_GRANT_IDX: begin
            used_in[grant_idx] = 1'b1;
            keep_in[grant_idx] = 1'b1;
            lvv_in[grant_idx]  = 1'b1;
            ram_we             = 1'b1;
            ram_waddr          = grant_idx;
            w_owner            = id_to_owner(item_ff.owner_id);
            emit               = 1'b1;
            beat.event_kind    = EV_GRANTED;
            beat.slot          = idx_to_slot(grant_idx);
            beat.slot_owner    = owner_to_id(id_to_owner(item_ff.owner_id));
         end
         CMD_TICK_SLOT: begin
            lvv_in[idx_ff]  = 1'b1;
            ram_we          = 1'b1;
            ram_waddr       = idx_ff;
            beat.slot       = idx_to_slot(idx_ff);
            beat.slot_owner = owner_to_id(tick_owner);
            beat.last       = (cnt_ff == CNT_BITS'(MAX_RESULTS - 1)) || !any_above;
            if (tick_new != '0) begin
               w_owner         = tick_owner;
               w_level         = tick_new;
               beat.event_kind = EV_ACTIVE;
               beat.level      = tick_new;
            end else begin
               used_in[idx_ff] = 1'b0;
               beat.event_kind = EV_RELEASED;
            end
            if (sts.rep_ok) begin
               emit   = 1'b1;
               cnt_in = cnt_ff + CNT_BITS'(1);
            end
         end
         default: begin
         end
      endcase

      if (cmd.clear_keep) begin
         keep_in = '0;
      end

      if (emit) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = beat;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      if (csr_valid) begin
         case (csr_addr)
            CFG_QUALITY:    quality_in = csr_wdata[QM_W-1:0];
            CFG_FADE_STEP:  step_in    = csr_wdata[LEVEL_W-1:0];
            CFG_FULL_LEVEL: full_in    = csr_wdata[LEVEL_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         quality_ff   <= QUALITY_RESET;
         step_ff      <= STEP_RESET;
         full_ff      <= FULL_RESET;
         used_ff      <= '0;
         keep_ff      <= '0;
         lvv_ff       <= '0;
         idx_ff       <= '0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         quality_ff   <= quality_in;
         step_ff      <= step_in;
         full_ff      <= full_in;
         used_ff      <= used_in;
         keep_ff      <= keep_in;
         lvv_ff       <= lvv_in;
         idx_ff       <= idx_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff     <= item_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

`default_nettype wire

// ===== sv/shadow_slot_lease_table.sv =====
// shadow slot lease table, one item at a time; results leave through an output register
// request: touch/return read the table first; free-slot grant scans slots top down
// tick: visits every slot in order, reads and rewrites each occupied one
// reset clears slot flags, counters and control, loads csr defaults; no clearing pass
// depends on sslt_pkg, sslt_ifs, sslt_ctrl, sslt_dpath, sslt_ram, assert_macros.svh
`default_nettype none
`include "assert_macros.svh"

module shadow_slot_lease_table (
   input  wire logic clock,
   input  wire logic reset,
   sslt_req_if.sink  req_if,
   sslt_rsp_if.source rsp_if,
   sslt_csr_if.sink  csr_if
);
   import sslt_pkg::*;

   cmd_type      cmd;
   sts_type      sts;
   logic         req_ready;
   logic         rsp_valid;
   rsp_beat_type rsp_data;

   sslt_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_if.valid),
      .req_ready(req_ready),
      .sts      (sts),
      .cmd      (cmd)
   );

   sslt_dpath u_dpath (
      .clock    (clock),
      .reset    (reset),
      .req_data (req_if.data),
      .cmd      (cmd),
      .sts      (sts),
      .csr_valid(csr_if.valid),
      .csr_addr (csr_if.addr),
      .csr_wdata(csr_if.wdata),
      .rsp_valid(rsp_valid),
      .rsp_data (rsp_data),
      .rsp_ready(rsp_if.ready)
   );

   assign req_if.ready = req_ready;
   assign csr_if.ready = 1'b1;
   assign rsp_if.valid = rsp_valid;
   assign rsp_if.data  = rsp_data;

   `ASSERT_NEVER(a_emit_full, clock, reset, (cmd.op != CMD_NONE) && !sts.out_free && !((cmd.op == CMD_TICK_SLOT) && !sts.rep_ok), "result beat issued while output register full")
   `ASSERT_CLK(a_single_last, clock, reset, rsp_if.valid && (rsp_if.data.event_kind != EV_ACTIVE) && (rsp_if.data.event_kind != EV_RELEASED) |-> rsp_if.data.last, "single beat result without last")
   `ASSERT_CLK(a_refuse_shape, clock, reset, rsp_if.valid && (rsp_if.data.event_kind == EV_REFUSED) |-> (rsp_if.data.slot == '0) && (rsp_if.data.slot_owner == '0) && (rsp_if.data.level == '0), "refusal beat carries slot data")
   `ASSERT_CLK(a_busy_after_accept, clock, reset, cmd.latch |=> !req_if.ready, "new beat taken while item in progress")

endmodule

`default_nettype wire
